[hw/rtl/xyzcct_pkg.sv]
// ----------------------------------------------------------------------------
// xyzcct_pkg
// Shared types, codes and isotemperature line tables for the XYZ to CCT block.
// ----------------------------------------------------------------------------
package xyzcct_pkg;

    localparam int LINES             = 31;
    localparam int IDX_W             = 5;
    localparam int CCT_FRAC_BITS_DEF = 4;
    localparam int CCT_W             = 24;
    localparam int DEN_W             = 37;
    localparam int UV_W              = 24;
    localparam int DIVR_W            = 42;
    localparam int DIVN_W            = 64;
    localparam int CNT_W             = 7;
    localparam int DIST_W            = 52;
    localparam int K_W               = 16;
    localparam int MIRED_W           = 42;
    localparam int P_W               = 33;
    localparam logic [CCT_W-1:0] CCT_MAX = '1;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_UDIV,
        OP_UGET,
        OP_VDIV,
        OP_VGET,
        OP_WSTEP,
        OP_MUL,
        OP_NORM,
        OP_PDIV,
        OP_PGET,
        OP_MIRED,
        OP_CDIV,
        OP_CGET,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic den_zero;
        logic div_busy;
        logic walk_found;
        logic walk_end;
        logic mul_last;
        logic norm_ok;
    } dp_stat_t;

    typedef struct packed {
        logic              start;
        logic [DIVR_W-1:0] divisor;
        logic [DIVR_W-1:0] rem_init;
        logic [DIVN_W-1:0] num_lo;
        logic [CNT_W-1:0]  count;
    } div_req_t;

    // table entry in units of 1e-5 to Q8.16, rounded to nearest
    function automatic logic [23:0] pq16(input logic [63:0] n);
        logic [63:0] t;
        t = (n * 64'd65536 + 64'd50000) / 64'd100000;
        return t[23:0];
    endfunction

    // 2^32 + t^2 for a Q8.16 slope magnitude
    function automatic logic [63:0] tsq(input logic [23:0] tm);
        return 64'h1_0000_0000 + 64'(tm) * 64'(tm);
    endfunction

    // integer square root, elaboration only
    function automatic logic [15:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = xin;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[15:0];
    endfunction

    localparam logic [23:0] LINE_U [LINES] = '{
        pq16(18006), pq16(18066), pq16(18133), pq16(18208), pq16(18293), pq16(18388),
        pq16(18494), pq16(18611), pq16(18740), pq16(18880), pq16(19032), pq16(19462),
        pq16(19962), pq16(20525), pq16(21142), pq16(21807), pq16(22511), pq16(23247),
        pq16(24010), pq16(24792), pq16(25591), pq16(26400), pq16(27218), pq16(28039),
        pq16(28863), pq16(29685), pq16(30505), pq16(31320), pq16(32129), pq16(32931),
        pq16(33724)
    };

    localparam logic [23:0] LINE_V [LINES] = '{
        pq16(26352), pq16(26589), pq16(26846), pq16(27119), pq16(27407), pq16(27709),
        pq16(28021), pq16(28342), pq16(28668), pq16(28997), pq16(29326), pq16(30141),
        pq16(30921), pq16(31647), pq16(32312), pq16(32909), pq16(33439), pq16(33904),
        pq16(34308), pq16(34655), pq16(34951), pq16(35200), pq16(35407), pq16(35577),
        pq16(35714), pq16(35823), pq16(35907), pq16(35968), pq16(36011), pq16(36038),
        pq16(36051)
    };

    // slope magnitudes, all slopes are negative
    localparam logic [23:0] LINE_TM [LINES] = '{
        pq16(24341), pq16(25479), pq16(26876), pq16(28539), pq16(30470),
        pq16(32675), pq16(35156), pq16(37915), pq16(40955), pq16(44278),
        pq16(47888), pq16(58204), pq16(70471), pq16(84901), pq16(101820),
        pq16(121680), pq16(145120), pq16(172980), pq16(206370), pq16(246810),
        pq16(296410), pq16(358140), pq16(436330), pq16(537620), pq16(672620),
        pq16(859550), pq16(1132400), pq16(1562800), pq16(2332500), pq16(4077000),
        pq16(11645000)
    };

    // distance scale, about 2^16/sqrt(1+t^2)
    localparam logic [K_W-1:0] LINE_K [LINES] = '{
        isqrt64(ALL_ONES / tsq(pq16(24341))),
        isqrt64(ALL_ONES / tsq(pq16(25479))),
        isqrt64(ALL_ONES / tsq(pq16(26876))),
        isqrt64(ALL_ONES / tsq(pq16(28539))),
        isqrt64(ALL_ONES / tsq(pq16(30470))),
        isqrt64(ALL_ONES / tsq(pq16(32675))),
        isqrt64(ALL_ONES / tsq(pq16(35156))),
        isqrt64(ALL_ONES / tsq(pq16(37915))),
        isqrt64(ALL_ONES / tsq(pq16(40955))),
        isqrt64(ALL_ONES / tsq(pq16(44278))),
        isqrt64(ALL_ONES / tsq(pq16(47888))),
        isqrt64(ALL_ONES / tsq(pq16(58204))),
        isqrt64(ALL_ONES / tsq(pq16(70471))),
        isqrt64(ALL_ONES / tsq(pq16(84901))),
        isqrt64(ALL_ONES / tsq(pq16(101820))),
        isqrt64(ALL_ONES / tsq(pq16(121680))),
        isqrt64(ALL_ONES / tsq(pq16(145120))),
        isqrt64(ALL_ONES / tsq(pq16(172980))),
        isqrt64(ALL_ONES / tsq(pq16(206370))),
        isqrt64(ALL_ONES / tsq(pq16(246810))),
        isqrt64(ALL_ONES / tsq(pq16(296410))),
        isqrt64(ALL_ONES / tsq(pq16(358140))),
        isqrt64(ALL_ONES / tsq(pq16(436330))),
        isqrt64(ALL_ONES / tsq(pq16(537620))),
        isqrt64(ALL_ONES / tsq(pq16(672620))),
        isqrt64(ALL_ONES / tsq(pq16(859550))),
        isqrt64(ALL_ONES / tsq(pq16(1132400))),
        isqrt64(ALL_ONES / tsq(pq16(1562800))),
        isqrt64(ALL_ONES / tsq(pq16(2332500))),
        isqrt64(ALL_ONES / tsq(pq16(4077000))),
        isqrt64(ALL_ONES / tsq(pq16(11645000)))
    };

    localparam logic [9:0] LINE_MIRED [LINES] = '{
        10'd0,   10'd10,  10'd20,  10'd30,  10'd40,  10'd50,  10'd60,  10'd70,
        10'd80,  10'd90,  10'd100, 10'd125, 10'd150, 10'd175, 10'd200, 10'd225,
        10'd250, 10'd275, 10'd300, 10'd325, 10'd350, 10'd375, 10'd400, 10'd425,
        10'd450, 10'd475, 10'd500, 10'd525, 10'd550, 10'd575, 10'd600
    };

endpackage

[hw/rtl/xyz_to_correlated_color_temp.sv]
// Sequence: an all-zero input goes straight to the result. Otherwise the
//   shared one-bit-per-cycle divider forms u and v and the line walk runs over
//   up to 31 lines; if a line pair brackets the point, the multiply, the
//   normalize shifts and the weight and temperature divisions follow.
// Throughput: one item at a time; the next input transfer is taken once the
//   result is in the output register. aresetn is synchronous, active low.
// ----------------------------------------------------------------------------
// xyz_to_correlated_color_temp
// Correlated color temperature from one XYZ triple by the isotemperature line
// method, result in fractional kelvin with a status code.
// ----------------------------------------------------------------------------
module xyz_to_correlated_color_temp
    import xyzcct_pkg::*;
#(
    parameter int CCT_FRAC_BITS = CCT_FRAC_BITS_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [31:0]      s_tristim_x,
    input  logic [31:0]      s_tristim_y,
    input  logic [31:0]      s_tristim_z,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CCT_W-1:0] m_cct_sixteenths,
    output logic [1:0]       m_status
);

    cmd_t     cmd;
    dp_stat_t stat;

    xyzcct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    xyzcct_dp #(
        .CCT_FRAC_BITS (CCT_FRAC_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_tristim_x      (s_tristim_x),
        .s_tristim_y      (s_tristim_y),
        .s_tristim_z      (s_tristim_z),
        .stat             (stat),
        .m_cct_sixteenths (m_cct_sixteenths),
        .m_status         (m_status)
    );

endmodule

[hw/rtl/xyzcct_div.sv]
// ----------------------------------------------------------------------------
// xyzcct_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module xyzcct_div
    import xyzcct_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    output logic              busy,
    output logic [DIVN_W-1:0] quot
);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [DIVR_W-1:0] dvs_reg;
    logic [DIVN_W-1:0] nsh_reg;
    logic [DIVN_W-1:0] q_reg;
    logic [DIVR_W:0]   trial;
    logic              fits;

    // trial subtract of the next partial remainder
    assign trial = {rem_reg, nsh_reg[DIVN_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= req.count;
        end else if (busy_reg) begin
            busy_reg <= cnt_reg != CNT_W'(1);
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    // remainder and quotient
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= req.rem_init;
            dvs_reg <= req.divisor;
            nsh_reg <= req.num_lo;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIVR_W'(trial - {1'b0, dvs_reg}) : trial[DIVR_W-1:0];
            nsh_reg <= {nsh_reg[DIVN_W-2:0], 1'b0};
            q_reg   <= {q_reg[DIVN_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

[hw/rtl/xyzcct_dp.sv]
// ----------------------------------------------------------------------------
// xyzcct_dp
// Datapath: chromaticity, line walk, weighting, interpolation, result.
// ----------------------------------------------------------------------------
module xyzcct_dp
    import xyzcct_pkg::*;
#(
    parameter int CCT_FRAC_BITS = CCT_FRAC_BITS_DEF
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  cmd_t             cmd,
    input  logic [31:0]      s_tristim_x,
    input  logic [31:0]      s_tristim_y,
    input  logic [31:0]      s_tristim_z,
    output dp_stat_t         stat,
    output logic [CCT_W-1:0] m_cct_sixteenths,
    output logic [1:0]       m_status
);

    localparam logic [63:0] NUM_BASE = 64'd1000000 << (CCT_FRAC_BITS + 32);

    logic [31:0]              x_reg, y_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [UV_W-1:0]          u_reg, v_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     found_reg, end_reg;
    logic signed [DIST_W-1:0] dprev_reg, dcur_reg;
    logic [1:0]               mph_reg;
    logic [63:0]              a_reg, b_reg;
    logic [P_W-1:0]           p_reg;
    logic [MIRED_W-1:0]       mired_reg;
    logic [CCT_W-1:0]         cct_reg;
    logic [CCT_W-1:0]         cct_out_reg;
    status_t                  status_reg;

    div_req_t          dreq;
    logic              dbusy;
    logic [DIVN_W-1:0] dquot;

    logic [IDX_W-1:0]         idx_prev;
    logic signed [25:0]       dv, du;
    logic signed [49:0]       tprod;
    logic signed [DIST_W-1:0] dist_now;
    logic [DIST_W-1:0]        magp, magc, msrc;
    logic [25:0]              mhalf;
    logic [K_W-1:0]           kval;
    logic [41:0]              mprod;
    logic [64:0]              sum;
    logic [33:0]              y3;
    logic [4:0]               dmired;
    logic [37:0]              wprod;

    xyzcct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .busy    (dbusy),
        .quot    (dquot)
    );

    assign idx_prev = idx_reg - IDX_W'(1);
    assign y3       = {1'b0, y_reg, 1'b0} + {2'b00, y_reg};

    // signed distance to the current line
    assign dv    = $signed({2'b00, v_reg}) - $signed({3'b000, LINE_V[idx_reg][15:0], 7'd0});
    assign du    = $signed({2'b00, u_reg}) - $signed({3'b000, LINE_U[idx_reg][15:0], 7'd0});
    assign tprod = $signed({1'b0, LINE_TM[idx_reg][22:0]}) * du;
    assign dist_now = $signed({{10{dv[25]}}, dv, 16'd0}) + $signed({{2{tprod[49]}}, tprod});

    // distance magnitudes times scale, two partial products each
    assign magp  = dprev_reg[DIST_W-1] ? (~dprev_reg + DIST_W'(1)) : dprev_reg;
    assign magc  = dcur_reg[DIST_W-1] ? (~dcur_reg + DIST_W'(1)) : dcur_reg;
    assign msrc  = mph_reg[1] ? magc : magp;
    assign mhalf = mph_reg[0] ? msrc[51:26] : msrc[25:0];
    assign kval  = mph_reg[1] ? LINE_K[idx_reg] : LINE_K[idx_prev];
    assign mprod = mhalf * kval;

    assign sum    = {1'b0, a_reg} + {1'b0, b_reg};
    assign dmired = 5'(LINE_MIRED[idx_reg] - LINE_MIRED[idx_prev]);
    assign wprod  = dmired * p_reg;

    // divider requests
    always_comb begin
        dreq = '0;
        case (cmd.op)
            OP_UDIV: begin
                dreq.start    = 1'b1;
                dreq.divisor  = DIVR_W'(den_reg);
                dreq.rem_init = DIVR_W'(x_reg[31:1]);
                dreq.num_lo   = {x_reg[0], 63'd0};
                dreq.count    = CNT_W'(26);
            end
            OP_VDIV: begin
                dreq.start    = 1'b1;
                dreq.divisor  = DIVR_W'(den_reg);
                dreq.rem_init = DIVR_W'(y3);
                dreq.count    = CNT_W'(24);
            end
            OP_PDIV: begin
                dreq.start    = 1'b1;
                dreq.divisor  = DIVR_W'(sum[31:0]);
                dreq.rem_init = DIVR_W'(a_reg[31:1]);
                dreq.num_lo   = {a_reg[0], 63'd0};
                dreq.count    = CNT_W'(33);
            end
            OP_CDIV: begin
                dreq.start    = 1'b1;
                dreq.divisor  = mired_reg;
                dreq.num_lo   = NUM_BASE + 64'(mired_reg[MIRED_W-1:1]);
                dreq.count    = CNT_W'(64);
            end
            default: begin
                dreq = '0;
            end
        endcase
    end

    // walk and multiply control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            found_reg <= 1'b0;
            end_reg   <= 1'b0;
            mph_reg   <= '0;
        end else begin
            case (cmd.op)
                OP_VGET: begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    end_reg   <= 1'b0;
                    mph_reg   <= '0;
                end
                OP_WSTEP: begin
                    if (!found_reg && !end_reg) begin
                        if (idx_reg != '0 && dist_now[DIST_W-1] != dprev_reg[DIST_W-1]) begin
                            found_reg <= 1'b1;
                        end else if (idx_reg == IDX_W'(LINES - 1)) begin
                            end_reg <= 1'b1;
                        end else begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                OP_MUL: begin
                    mph_reg <= mph_reg + 2'd1;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                x_reg   <= s_tristim_x;
                y_reg   <= s_tristim_y;
                den_reg <= {5'd0, s_tristim_x} + ({5'd0, s_tristim_y} << 4)
                         - {5'd0, s_tristim_y} + ({5'd0, s_tristim_z} << 1)
                         + {5'd0, s_tristim_z};
            end
            OP_UGET: begin
                u_reg <= (dquot[63:24] != '0) ? '1 : dquot[23:0];
            end
            OP_VGET: begin
                v_reg <= dquot[23:0];
            end
            OP_WSTEP: begin
                if (!found_reg && !end_reg) begin
                    if (idx_reg != '0 && dist_now[DIST_W-1] != dprev_reg[DIST_W-1]) begin
                        dcur_reg <= dist_now;
                    end else begin
                        dprev_reg <= dist_now;
                    end
                end
            end
            OP_MUL: begin
                case (mph_reg)
                    2'd0:    a_reg <= 64'(mprod);
                    2'd1:    a_reg <= a_reg + (64'(mprod) << 26);
                    2'd2:    b_reg <= 64'(mprod);
                    default: b_reg <= b_reg + (64'(mprod) << 26);
                endcase
            end
            OP_NORM: begin
                a_reg <= a_reg >> 1;
                b_reg <= b_reg >> 1;
            end
            OP_PGET: begin
                p_reg <= (sum[31:0] == '0) ? '0 : dquot[P_W-1:0];
            end
            OP_MIRED: begin
                mired_reg <= {LINE_MIRED[idx_prev], 32'd0} + MIRED_W'(wprod);
            end
            OP_CGET: begin
                cct_reg <= (mired_reg == '0 || dquot[63:24] != '0) ? CCT_MAX : dquot[23:0];
            end
            OP_OUT: begin
                status_reg  <= cmd.code;
                cct_out_reg <= (cmd.code == ST_OK) ? cct_reg : '0;
            end
            default: begin
            end
        endcase
    end

    // status to the controller
    assign stat.den_zero   = den_reg == '0;
    assign stat.div_busy   = dbusy;
    assign stat.walk_found = found_reg;
    assign stat.walk_end   = end_reg;
    assign stat.mul_last   = mph_reg == 2'd3;
    assign stat.norm_ok    = sum[64:32] == '0;

    assign m_cct_sixteenths = cct_out_reg;
    assign m_status         = status_reg;

endmodule

[hw/rtl/xyzcct_ctrl.sv]
// ----------------------------------------------------------------------------
// xyzcct_ctrl
// Sequencer: issues datapath operations and runs both handshakes.
// ----------------------------------------------------------------------------
module xyzcct_ctrl
    import xyzcct_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZCHK,
        S_UWAIT,
        S_VDIV,
        S_VWAIT,
        S_WALK,
        S_MUL,
        S_NORM,
        S_PWAIT,
        S_MIRED,
        S_CDIV,
        S_CWAIT,
        S_OUT
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    m_valid_reg, m_valid_next;

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = m_valid_reg;

    // next state and operation
    always_comb begin
        state_next   = state_reg;
        code_next    = code_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd.op       = OP_NOP;
        cmd.code     = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ZCHK;
                end
            end
            S_ZCHK: begin
                if (stat.den_zero) begin
                    code_next  = ST_ZERO;
                    state_next = S_OUT;
                end else begin
                    cmd.op     = OP_UDIV;
                    state_next = S_UWAIT;
                end
            end
            S_UWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_UGET;
                    state_next = S_VDIV;
                end
            end
            S_VDIV: begin
                cmd.op     = OP_VDIV;
                state_next = S_VWAIT;
            end
            S_VWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_VGET;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.walk_found) begin
                    state_next = S_MUL;
                end else if (stat.walk_end) begin
                    code_next  = ST_RANGE;
                    state_next = S_OUT;
                end else begin
                    cmd.op = OP_WSTEP;
                end
            end
            S_MUL: begin
                cmd.op = OP_MUL;
                if (stat.mul_last) begin
                    state_next = S_NORM;
                end
            end
            S_NORM: begin
                if (stat.norm_ok) begin
                    cmd.op     = OP_PDIV;
                    state_next = S_PWAIT;
                end else begin
                    cmd.op = OP_NORM;
                end
            end
            S_PWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_PGET;
                    state_next = S_MIRED;
                end
            end
            S_MIRED: begin
                cmd.op     = OP_MIRED;
                state_next = S_CDIV;
            end
            S_CDIV: begin
                cmd.op     = OP_CDIV;
                state_next = S_CWAIT;
            end
            S_CWAIT: begin
                if (!stat.div_busy) begin
                    cmd.op     = OP_CGET;
                    code_next  = ST_OK;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.op       = OP_OUT;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            code_reg    <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hw/rtl/xyzcct_chk.sv]
// ----------------------------------------------------------------------------
// xyzcct_chk
// Port checker for the XYZ to CCT block, bound to the top level.
// ----------------------------------------------------------------------------
module xyzcct_chk
    import xyzcct_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic [31:0]      s_tristim_x,
    input logic [31:0]      s_tristim_y,
    input logic [31:0]      s_tristim_z,
    input logic             m_valid,
    input logic             m_ready,
    input logic [CCT_W-1:0] m_cct_sixteenths,
    input logic [1:0]       m_status
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_cct_sixteenths) && $stable(m_status))
        else $error("result payload changed while stalled");

    // temperature is zero unless status ok
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_cct_sixteenths == '0)
        else $error("nonzero temperature with failing status");

    // only defined status codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_ZERO || m_status == ST_RANGE))
        else $error("undefined status code");

    // one item in flight: no transfer right after a transfer
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

endmodule

bind xyz_to_correlated_color_temp xyzcct_chk u_chk (.*);
